// ----- sv/rvpa_pkg.sv -----
// Package of shared constants, types and codes for the radial vignette pixel block.
package rvpa_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_SIDE    = 4096;
    localparam int QUEUE_DEPTH = 32;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int IDX_W      = 12;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int TABLE_AW = $clog2(TABLE_DEPTH);
    localparam int CLAMP_W  = (SIDE_W > CFG_DATA_W) ? SIDE_W : CFG_DATA_W;

    localparam int COORD_SPAN = 2 * ((1 << COORD_W) - 1);
    localparam int MAG_MAX    = (MAX_SIDE - 1 > COORD_SPAN) ? MAX_SIDE - 1 : COORD_SPAN;
    localparam int MAG_W      = $clog2(MAG_MAX + 1);
    localparam int DIFF_W     = MAG_W + 2;
    localparam int SQ_W       = 2 * MAG_W + 1;
    localparam int RT_W       = MAG_W + 1;
    localparam int RADICAND_W = 2 * RT_W;
    localparam int REM_W      = RT_W + 2;
    localparam int RAD_W      = RT_W - 1;
    localparam int EXT_A      = (RAD_W > IDX_W) ? RAD_W : IDX_W;
    localparam int EXT_W      = ((EXT_A > TABLE_AW) ? EXT_A : TABLE_AW) + 1;

    localparam int FRAC_W     = 14;
    localparam int WEIGHT_ONE = 16384;
    localparam int F2_W       = WEIGHT_W + 1;
    localparam int PROD_W     = PIX_W + F2_W;
    localparam int HI_W       = PROD_W - FRAC_W;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;

    localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QAW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QAW + 1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_TINT_RED     = 3'd2,
        CFG_TINT_GREEN   = 3'd3,
        CFG_TINT_BLUE    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                       command;
        logic [COORD_W-1:0]         column;
        logic [COORD_W-1:0]         row;
        logic [PIX_W-1:0]           red_in;
        logic [PIX_W-1:0]           green_in;
        logic [PIX_W-1:0]           blue_in;
        logic [PIX_W-1:0]           alpha_in;
        logic [IDX_W-1:0]           entry_index;
        logic signed [WEIGHT_W-1:0] entry_weight;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic [PIX_W-1:0] alpha_out;
    } t_out_item;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_tint;

    typedef struct packed {
        logic                is_pixel;
        logic                wr_ok;
        logic [TABLE_AW-1:0] addr;
        logic [WEIGHT_W-1:0] weight;
        logic [PIX_W-1:0]    red;
        logic [PIX_W-1:0]    green;
        logic [PIX_W-1:0]    blue;
        logic [PIX_W-1:0]    alpha;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_push;

endpackage

// ----- sv/radial_vignette_pixel_apply_core.sv -----
// Top level of the radial vignette pixel block: configuration registers and the core.
//
// Input channel (i_valid, o_ready, i_item) carries load beats, which write one
// signed Q2.14 weight into the radius table, and pixel beats, which return one
// adjusted RGBA beat on the output channel (o_valid, i_ready, o_item).
// Configuration writes (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) set
// image width, image height and the tint colour; o_cfg_ready is always high.
// Throughput is one beat per cycle unless o_ready drops or the receiver stalls.
// On a pixel beat's path to the output, three stages form the squared distance,
// one square-root stage per result bit follows, then the queue, the table
// read, the scaling multiply and the output register.
// The 32-entry queue between radius and table stages lets input keep flowing
// while the receiver stalls; o_ready drops once 32 beats are in flight or
// queued, and the back end freezes while its output beat waits.
// Reset clears all control state, the width and height to one and the tint to
// black. The weight table is not cleared: each entry must be loaded before a
// pixel at that radius is sent.
module radial_vignette_pixel_apply_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  rvpa_pkg::t_in_item               i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output rvpa_pkg::t_out_item              o_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rvpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rvpa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rvpa_pkg::*;

    logic [SIDE_W-1:0]  r_width;
    logic [SIDE_W-1:0]  r_height;
    t_tint              r_tint;
    logic [CLAMP_W-1:0] cfg_ext;
    logic [SIDE_W-1:0]  side_clamped;
    logic               cfg_we;

    t_push              push;
    logic               pop;
    logic               q_empty;
    t_q_entry           q_head;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        cfg_ext = CLAMP_W'(i_cfg_data);
        if (cfg_ext == '0) begin
            side_clamped = SIDE_W'(1);
        end else if (cfg_ext > CLAMP_W'(MAX_SIDE)) begin
            side_clamped = SIDE_W'(MAX_SIDE);
        end else begin
            side_clamped = SIDE_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_W'(1);
            r_height <= SIDE_W'(1);
            r_tint   <= '0;
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_width <= side_clamped;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= side_clamped;
                end
                CFG_TINT_RED: begin
                    r_tint.red <= i_cfg_data[PIX_W-1:0];
                end
                CFG_TINT_GREEN: begin
                    r_tint.green <= i_cfg_data[PIX_W-1:0];
                end
                CFG_TINT_BLUE: begin
                    r_tint.blue <= i_cfg_data[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rvpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_width  (r_width),
        .i_height (r_height),
        .i_pop    (pop),
        .o_push   (push)
    );

    rvpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    rvpa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tint    (r_tint),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

// ----- sv/rvpa_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module rvpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rvpa_front.sv -----
// Front end: accepts beats, computes the pixel radius with a pipelined square root.
module rvpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rvpa_pkg::t_in_item            i_item,
    input  logic [rvpa_pkg::SIDE_W-1:0]   i_width,
    input  logic [rvpa_pkg::SIDE_W-1:0]   i_height,
    input  logic                          i_pop,
    output rvpa_pkg::t_push               o_push
);
    import rvpa_pkg::*;

    logic                  accept;
    logic [CRED_W-1:0]     r_credit;
    logic [CRED_W-1:0]     n_credit;

    logic [DIFF_W-1:0]     dx;
    logic [DIFF_W-1:0]     dy;
    logic [DIFF_W-1:0]     dx_abs;
    logic [DIFF_W-1:0]     dy_abs;

    logic                  r_p1_valid;
    t_in_item              r_p1_item;
    logic [MAG_W-1:0]      r_p1_magx;
    logic [MAG_W-1:0]      r_p1_magy;

    logic                  r_p2_valid;
    t_in_item              r_p2_item;
    logic [2*MAG_W-1:0]    r_p2_sqx;
    logic [2*MAG_W-1:0]    r_p2_sqy;

    logic [RT_W:0]         r_sv;
    t_in_item              r_pl   [RT_W+1];
    logic [RADICAND_W-1:0] r_rad  [RT_W+1];
    logic [REM_W-1:0]      r_rem  [RT_W+1];
    logic [RT_W-1:0]       r_root [RT_W+1];
    logic [RADICAND_W-1:0] n_rad  [RT_W];
    logic [REM_W-1:0]      n_rem  [RT_W];
    logic [RT_W-1:0]       n_root [RT_W];

    logic [EXT_W-1:0]      rad_ext;
    logic [EXT_W-1:0]      idx_ext;
    logic [TABLE_AW-1:0]   rad_addr;
    t_in_item              last_item;

    assign o_ready = r_credit < CRED_W'(QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_credit = r_credit;
        if (accept && !i_pop) begin
            n_credit = r_credit + CRED_W'(1);
        end else if (!accept && i_pop) begin
            n_credit = r_credit - CRED_W'(1);
        end
    end

    always_comb begin
        dx     = DIFF_W'(i_width) - DIFF_W'(1) - (DIFF_W'(i_item.column) << 1);
        dy     = DIFF_W'(i_height) - DIFF_W'(1) - (DIFF_W'(i_item.row) << 1);
        dx_abs = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
        dy_abs = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
    end

    always_comb begin
        logic [REM_W+1:0] nxt;
        logic [REM_W+1:0] trial;
        for (int k = 0; k < RT_W; k++) begin
            nxt       = {r_rem[k], r_rad[k][RADICAND_W-1 -: 2]};
            trial     = (REM_W+2)'({r_root[k], 2'b01});
            n_rad[k]  = r_rad[k] << 2;
            if (nxt >= trial) begin
                n_rem[k]  = REM_W'(nxt - trial);
                n_root[k] = {r_root[k][RT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = REM_W'(nxt);
                n_root[k] = {r_root[k][RT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit   <= '0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_sv       <= '0;
        end else begin
            r_credit   <= n_credit;
            r_p1_valid <= accept;
            r_p2_valid <= r_p1_valid;
            r_sv       <= {r_sv[RT_W-1:0], r_p2_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_item <= i_item;
        r_p1_magx <= dx_abs[MAG_W-1:0];
        r_p1_magy <= dy_abs[MAG_W-1:0];
        r_p2_item <= r_p1_item;
        r_p2_sqx  <= r_p1_magx * r_p1_magx;
        r_p2_sqy  <= r_p1_magy * r_p1_magy;
        r_pl[0]   <= r_p2_item;
        r_rad[0]  <= RADICAND_W'(SQ_W'(r_p2_sqx) + SQ_W'(r_p2_sqy));
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        for (int k = 0; k < RT_W; k++) begin
            r_pl[k+1]   <= r_pl[k];
            r_rad[k+1]  <= n_rad[k];
            r_rem[k+1]  <= n_rem[k];
            r_root[k+1] <= n_root[k];
        end
    end

    always_comb begin
        last_item = r_pl[RT_W];
        rad_ext   = EXT_W'(r_root[RT_W][RT_W-1:1]);
        idx_ext   = EXT_W'(last_item.entry_index);
        rad_addr  = (rad_ext >= EXT_W'(TABLE_DEPTH)) ? TABLE_AW'(TABLE_DEPTH - 1)
                                                      : rad_ext[TABLE_AW-1:0];
        o_push.valid          = r_sv[RT_W];
        o_push.entry.is_pixel = (last_item.command == CMD_PIXEL);
        o_push.entry.wr_ok    = idx_ext < EXT_W'(TABLE_DEPTH);
        o_push.entry.addr     = (last_item.command == CMD_PIXEL) ? rad_addr
                                                                 : idx_ext[TABLE_AW-1:0];
        o_push.entry.weight   = last_item.entry_weight;
        o_push.entry.red      = last_item.red_in;
        o_push.entry.green    = last_item.green_in;
        o_push.entry.blue     = last_item.blue_in;
        o_push.entry.alpha    = last_item.alpha_in;
    end

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRED_W'(QUEUE_DEPTH))
        else $error("Credit count exceeds the queue depth.");

    a_credit_covers_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_sv, r_p1_valid, r_p2_valid}) <= int'(r_credit))
        else $error("More beats in flight than credits taken.");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(RT_W + 3) o_push.valid)
        else $error("Accepted beat did not reach the queue on time.");
`endif

endmodule

// ----- sv/rvpa_queue.sv -----
// Queue of classified beats between the front end and the back end.
module rvpa_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rvpa_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_empty,
    output rvpa_pkg::t_q_entry  o_head
);
    import rvpa_pkg::*;

    t_q_entry          r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]    r_wr;
    logic [QAW-1:0]    r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr <= (r_wr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_count != QCNT_W'(QUEUE_DEPTH)) || i_pop)
        else $error("Queue overflow.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("Queue read while empty.");
`endif

endmodule

// ----- sv/rvpa_back.sv -----
// Back end: weight table access, per-channel scaling and the output register.
module rvpa_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rvpa_pkg::t_tint      i_tint,
    input  logic                 i_q_empty,
    input  rvpa_pkg::t_q_entry   i_q_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rvpa_pkg::t_out_item  o_item
);
    import rvpa_pkg::*;

    logic                       en;
    logic                       ram_we;
    logic signed [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0]        ram_rdata;

    logic                       r_b1_valid;
    logic                       r_b1_pixel;
    logic [PIX_W-1:0]           r_b1_red;
    logic [PIX_W-1:0]           r_b1_green;
    logic [PIX_W-1:0]           r_b1_blue;
    logic [PIX_W-1:0]           r_b1_alpha;

    logic                       r_b2_valid;
    logic [PROD_W-1:0]          r_b2_red;
    logic [PROD_W-1:0]          r_b2_green;
    logic [PROD_W-1:0]          r_b2_blue;
    logic [PIX_W-1:0]           r_b2_alpha;

    logic                       r_out_valid;
    t_out_item                  r_out;

    function automatic logic [PROD_W-1:0] f_scale(
        input logic [PIX_W-1:0]           c,
        input logic [PIX_W-1:0]           tint,
        input logic signed [WEIGHT_W-1:0] w
    );
        logic [PIX_W-1:0]  f1;
        logic [F2_W-1:0]   f2;
        logic [PROD_W-1:0] off;
        if (w[WEIGHT_W-1]) begin
            f1  = c;
            f2  = F2_W'(WEIGHT_ONE) - F2_W'(w);
            off = '0;
        end else begin
            f1  = tint;
            f2  = F2_W'(w);
            off = PROD_W'({c, FRAC_W'(0)});
        end
        return PROD_W'(f1) * PROD_W'(f2) + off;
    endfunction

    function automatic logic [PIX_W-1:0] f_sat(input logic [PROD_W-1:0] p);
        logic [HI_W-1:0] hi;
        hi = p[PROD_W-1:FRAC_W];
        return (hi > HI_W'(PIX_MAX)) ? PIX_MAX : hi[PIX_W-1:0];
    endfunction

    assign en     = !r_out_valid || i_ready;
    assign o_pop  = en && !i_q_empty;
    assign ram_we = o_pop && !i_q_head.is_pixel && i_q_head.wr_ok;
    assign weight = $signed(ram_rdata);

    rvpa_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_head.addr),
        .i_wdata (i_q_head.weight),
        .i_re    (o_pop),
        .i_raddr (i_q_head.addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid  <= o_pop;
            r_b2_valid  <= r_b1_valid && r_b1_pixel;
            r_out_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_pixel      <= i_q_head.is_pixel;
            r_b1_red        <= i_q_head.red;
            r_b1_green      <= i_q_head.green;
            r_b1_blue       <= i_q_head.blue;
            r_b1_alpha      <= i_q_head.alpha;
            r_b2_red        <= f_scale(r_b1_red, i_tint.red, weight);
            r_b2_green      <= f_scale(r_b1_green, i_tint.green, weight);
            r_b2_blue       <= f_scale(r_b1_blue, i_tint.blue, weight);
            r_b2_alpha      <= r_b1_alpha;
            r_out.red_out   <= f_sat(r_b2_red);
            r_out.green_out <= f_sat(r_b2_green);
            r_out.blue_out  <= f_sat(r_b2_blue);
            r_out.alpha_out <= r_b2_alpha;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
